[rtl/core/tlbprt_pkg.sv]
// package: sizes, request and result types and the cell-to-cell record of the replacement tracker
package tlbprt_pkg;

    localparam int MAX_FRAMES_DEF = 64;
    localparam int MAX_TLB_DEF    = 16;
    localparam int ADDR_BITS_DEF  = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 7;
    localparam int SLOT_W         = 6;
    localparam int STAMP_W        = 32;
    // cells between two pipeline registers of a search chain
    localparam int CHAIN_SEG      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TLB      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LRU = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TLB_LRU  = 3'd4;

    typedef struct packed {
        logic        action;
        logic [31:0] address;
    } tlbprt_req_t;

    typedef struct packed {
        logic        tlb_hit;
        logic        page_fault;
        logic        wrote_back;
        logic [5:0]  frame_slot;
        logic [31:0] tlb_miss_total;
        logic [31:0] page_fault_total;
        logic [31:0] disk_write_total;
    } tlbprt_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TSCAN,
        ST_FSCAN,
        ST_UPDATE,
        ST_DIRTY,
        ST_RESP
    } tlbprt_state_t;

    // running search record handed from one cell to the next
    typedef struct packed {
        logic                found;
        logic [9:0]          first_idx;
        logic [STAMP_W-1:0]  min_stamp;
        logic [9:0]          min_idx;
        logic                min_dirty;
        logic                probe_dirty;
    } tlbprt_scan_t;

    // command broadcast to all cells of a chain
    typedef struct packed {
        logic               match_upd;
        logic               wr_idx_en;
        logic [9:0]         wr_idx;
        logic               wr_stamp;
        logic               set_dirty;
        logic               clr_dirty;
        logic               dirty_match;
    } tlbprt_cmd_t;

endpackage

[rtl/core/tlbprt_cell.sv]
// one entry cell: page tag, use stamp, dirty bit and its link in the search chain
module tlbprt_cell
    import tlbprt_pkg::*;
#(
    parameter int PAGE_W = 32,
    parameter int INDEX  = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                active,
    input  logic [PAGE_W-1:0]   page,
    input  logic [STAMP_W-1:0]  stamp,
    input  logic [9:0]          probe,
    input  tlbprt_cmd_t         cmd,
    input  tlbprt_scan_t        scan_in,
    output tlbprt_scan_t        scan_out
);

    logic [PAGE_W-1:0]  page_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic               dirty_reg;
    logic               hit;
    logic               sel;

    assign hit = active && (page_reg == page);
    assign sel = cmd.wr_idx_en && (cmd.wr_idx == 10'(INDEX));

    always_comb begin
        scan_out = scan_in;
        if (hit && !scan_in.found) begin
            scan_out.found     = 1'b1;
            scan_out.first_idx = 10'(INDEX);
        end
        if (active && (INDEX == 0 || stamp_reg < scan_in.min_stamp)) begin
            scan_out.min_stamp = stamp_reg;
            scan_out.min_idx   = 10'(INDEX);
            scan_out.min_dirty = dirty_reg;
        end
        if (INDEX == 0 && !active) begin
            scan_out.min_stamp = stamp_reg;
            scan_out.min_idx   = '0;
            scan_out.min_dirty = dirty_reg;
        end
        if (active && (probe == 10'(INDEX)))
            scan_out.probe_dirty = dirty_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg  <= PAGE_W'(INDEX);
            stamp_reg <= '0;
            dirty_reg <= 1'b0;
        end else begin
            if (sel)
                page_reg <= page;
            if ((sel && cmd.wr_stamp) || (cmd.match_upd && hit))
                stamp_reg <= stamp;
            if (cmd.dirty_match && hit)
                dirty_reg <= 1'b1;
            else if (sel && cmd.clr_dirty)
                dirty_reg <= 1'b0;
            else if (cmd.set_dirty && (sel || (cmd.match_upd && hit)))
                dirty_reg <= 1'b1;
        end
    end

endmodule

[rtl/core/tlbprt_chain.sv]
// row of entry cells linked into one search chain, registered every few cells and at the end
module tlbprt_chain
    import tlbprt_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int PAGE_W = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [10:0]         count,
    input  logic [PAGE_W-1:0]   page,
    input  logic [STAMP_W-1:0]  stamp,
    input  logic [9:0]          probe,
    input  tlbprt_cmd_t         cmd,
    output tlbprt_scan_t        result
);

    tlbprt_scan_t links [DEPTH+1];
    tlbprt_scan_t cell_out [DEPTH];
    tlbprt_scan_t result_reg;

    assign links[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        tlbprt_cell #(
            .PAGE_W(PAGE_W),
            .INDEX (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .active  (11'(g) < count),
            .page    (page),
            .stamp   (stamp),
            .probe   (probe),
            .cmd     (cmd),
            .scan_in (links[g]),
            .scan_out(cell_out[g])
        );
        if (((g + 1) % CHAIN_SEG == 0) && (g != DEPTH - 1)) begin : g_stage
            tlbprt_scan_t stage_reg;
            always_ff @(posedge aclk) begin
                stage_reg <= cell_out[g];
            end
            assign links[g+1] = stage_reg;
        end else begin : g_pass
            assign links[g+1] = cell_out[g];
        end
    end

    always_ff @(posedge aclk) begin
        result_reg <= links[DEPTH];
    end

    assign result = result_reg;

endmodule

[rtl/core/tlb_page_replacement_tracker.sv]
// top level: TLB and frame table replacement tracker
// The TLB and frame tables are rows of cells, each comparing its tag and passing the running
// first match, least-recent stamp and pointer-victim dirty bit to its neighbor, with a
// register after every eight cells. A request searches both chains in the scan state, then
// passes through the frame settle, update, dirty marking and result states. A new request
// is taken only after the previous result has been handed over. Configuration is to be
// written only while idle; the user must keep to this, the block itself does not enforce it.
module tlb_page_replacement_tracker
    import tlbprt_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int MAX_TLB    = MAX_TLB_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tlbprt_req_t           s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tlbprt_rsp_t           m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int MAX_DEPTH = (MAX_FRAMES > MAX_TLB) ? MAX_FRAMES : MAX_TLB;
    localparam int SCAN_CYC  = (MAX_DEPTH + CHAIN_SEG - 1) / CHAIN_SEG;
    localparam int SCW       = $clog2(SCAN_CYC + 1);

    logic [6:0] frames_reg;
    logic [4:0] tlbn_reg;
    logic [4:0] shift_reg;
    logic       page_lru_reg, tlb_lru_reg;

    tlbprt_state_t state_reg, state_next;
    logic [SCW-1:0] scan_cnt_reg;
    logic          wr_reg;
    logic [31:0]   page_reg;
    logic [31:0]   clock_reg, miss_reg, fault_reg, wb_reg;
    logic [9:0]    tptr_reg, fptr_reg;
    logic          hit_reg, fault_now_reg, wbk_reg;
    logic [9:0]    slot_reg;
    logic [10:0]   nf_reg, nt_reg;
    tlbprt_rsp_t   rsp_reg;
    logic          m_valid_reg;

    tlbprt_scan_t tres, fres;
    tlbprt_cmd_t  tcmd, fcmd;
    logic [10:0]  nf_c, nt_c;
    logic [31:0]  addr_m;
    logic [9:0]   tptr_use, fptr_use, fvict, tvict;

    always_comb begin
        nf_c = (frames_reg == 7'd0) ? 11'd1 :
               (11'(frames_reg) > 11'(MAX_FRAMES)) ? 11'(MAX_FRAMES) : 11'(frames_reg);
        nt_c = (tlbn_reg == 5'd0) ? 11'd1 :
               (11'(tlbn_reg) > 11'(MAX_TLB)) ? 11'(MAX_TLB) : 11'(tlbn_reg);
        if (nt_c > nf_c) nt_c = nf_c;
        addr_m = s_data.address & (32'hFFFF_FFFF >> (32 - ADDR_BITS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg   <= 7'd64;
            tlbn_reg     <= 5'd16;
            shift_reg    <= 5'd12;
            page_lru_reg <= 1'b0;
            tlb_lru_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FRAMES:   frames_reg   <= cfg_data;
                CFG_TLB:      tlbn_reg     <= cfg_data[4:0];
                CFG_SHIFT:    shift_reg    <= cfg_data[4:0];
                CFG_PAGE_LRU: page_lru_reg <= cfg_data[0];
                CFG_TLB_LRU:  tlb_lru_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    tlbprt_chain #(.DEPTH(MAX_TLB), .PAGE_W(32)) u_tlb (
        .aclk(aclk), .aresetn(aresetn), .count(nt_reg), .page(page_reg),
        .stamp(clock_reg), .probe(10'd0), .cmd(tcmd), .result(tres)
    );

    tlbprt_chain #(.DEPTH(MAX_FRAMES), .PAGE_W(32)) u_frm (
        .aclk(aclk), .aresetn(aresetn), .count(nf_reg), .page(page_reg),
        .stamp(clock_reg), .probe(fptr_use), .cmd(fcmd), .result(fres)
    );

    always_comb begin
        tptr_use   = (11'(tptr_reg) < nt_reg) ? tptr_reg : '0;
        fptr_use   = (11'(fptr_reg) < nf_reg) ? fptr_reg : '0;
        fvict      = page_lru_reg ? fres.min_idx : fptr_use;
        tvict      = tlb_lru_reg ? tres.min_idx : tptr_use;
        state_next = state_reg;
        tcmd       = '0;
        fcmd       = '0;
        unique case (state_reg)
            ST_IDLE:   if (s_valid && !m_valid_reg) state_next = ST_TSCAN;
            ST_TSCAN:  if (scan_cnt_reg == SCW'(SCAN_CYC - 1)) state_next = ST_FSCAN;
            ST_FSCAN:  state_next = ST_UPDATE;
            ST_UPDATE: begin
                state_next = ST_DIRTY;
                if (tres.found) begin
                    tcmd.wr_idx_en = 1'b1;
                    tcmd.wr_idx    = tres.first_idx;
                    tcmd.wr_stamp  = 1'b1;
                    tcmd.match_upd = 1'b0;
                    fcmd.match_upd = 1'b1;
                    fcmd.set_dirty = wr_reg;
                    // tlb entry keeps its page, only the stamp changes
                end else begin
                    tcmd.wr_idx_en = 1'b1;
                    tcmd.wr_idx    = tvict;
                    tcmd.wr_stamp  = tlb_lru_reg;
                    if (fres.found) begin
                        fcmd.wr_idx_en = 1'b1;
                        fcmd.wr_idx    = fres.first_idx;
                        fcmd.wr_stamp  = 1'b1;
                        fcmd.set_dirty = wr_reg;
                    end else begin
                        fcmd.wr_idx_en = 1'b1;
                        fcmd.wr_idx    = fvict;
                        fcmd.wr_stamp  = page_lru_reg;
                        fcmd.clr_dirty = 1'b1;
                    end
                end
            end
            ST_DIRTY: begin
                state_next       = ST_RESP;
                fcmd.dirty_match = wr_reg && fault_now_reg;
            end
            ST_RESP: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            clock_reg    <= '0;
            miss_reg     <= '0;
            fault_reg    <= '0;
            wb_reg       <= '0;
            tptr_reg     <= '0;
            fptr_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (s_valid && !m_valid_reg) begin
                    wr_reg       <= s_data.action;
                    page_reg     <= addr_m >> shift_reg;
                    nf_reg       <= nf_c;
                    nt_reg       <= nt_c;
                    clock_reg    <= clock_reg + 32'd1;
                    scan_cnt_reg <= '0;
                end
                ST_TSCAN: scan_cnt_reg <= scan_cnt_reg + SCW'(1);
                ST_UPDATE: begin
                    hit_reg       <= tres.found;
                    fault_now_reg <= 1'b0;
                    wbk_reg       <= 1'b0;
                    if (tres.found) begin
                        slot_reg <= fres.found ? fres.first_idx : '0;
                    end else begin
                        miss_reg <= miss_reg + 32'd1;
                        if (tlb_lru_reg) tptr_reg <= tres.min_idx;
                        else tptr_reg <= (11'(tptr_use) + 11'd1 >= nt_reg) ? '0
                                                                          : tptr_use + 10'd1;
                        if (fres.found) begin
                            slot_reg <= fres.first_idx;
                        end else begin
                            slot_reg      <= fvict;
                            fault_now_reg <= 1'b1;
                            fault_reg     <= fault_reg + 32'd1;
                            if (page_lru_reg) fptr_reg <= fres.min_idx;
                            else fptr_reg <= (11'(fptr_use) + 11'd1 >= nf_reg) ? '0
                                                                              : fptr_use + 10'd1;
                            if (page_lru_reg ? fres.min_dirty : fres.probe_dirty) begin
                                wbk_reg <= 1'b1;
                                wb_reg  <= wb_reg + 32'd1;
                            end
                        end
                    end
                end
                ST_RESP: m_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RESP) begin
            rsp_reg.tlb_hit          <= hit_reg;
            rsp_reg.page_fault       <= fault_now_reg;
            rsp_reg.wrote_back       <= wbk_reg;
            rsp_reg.frame_slot       <= slot_reg[5:0];
            rsp_reg.tlb_miss_total   <= miss_reg;
            rsp_reg.page_fault_total <= fault_reg;
            rsp_reg.disk_write_total <= wb_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    a_valid_after_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP) |=> m_valid) else $error("result missing");
    a_fault_implies_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.tlb_hit && m_data.page_fault)) else $error("hit with fault");

endmodule

[bench/tlb_page_replacement_tracker_tb.sv]
// testbench: random and directed requests against a built-in model of the replacement tracker
module tlb_page_replacement_tracker_tb
    import tlbprt_pkg::*;
;

    class tracker_scoreboard;
        logic [6:0]  n_frames;
        logic [4:0]  n_tlb;
        logic [4:0]  shift;
        bit          page_lru;
        bit          tlb_lru;
        logic [31:0] tlb_page [MAX_TLB_DEF];
        logic [31:0] tlb_stamp [MAX_TLB_DEF];
        logic [31:0] frame_page [MAX_FRAMES_DEF];
        logic [31:0] frame_stamp [MAX_FRAMES_DEF];
        bit          frame_dirty [MAX_FRAMES_DEF];
        int unsigned tlb_ptr;
        int unsigned frame_ptr;
        logic [31:0] clock_now;
        logic [31:0] misses;
        logic [31:0] faults;
        logic [31:0] writebacks;
        tlbprt_rsp_t pending [$];
        int          mismatches;

        function new();
            n_frames = 7'd64; n_tlb = 5'd16; shift = 5'd12; page_lru = 1'b0; tlb_lru = 1'b0;
            for (int i = 0; i < MAX_TLB_DEF; i++) begin
                tlb_page[i] = i; tlb_stamp[i] = 0;
            end
            for (int i = 0; i < MAX_FRAMES_DEF; i++) begin
                frame_page[i] = i; frame_stamp[i] = 0; frame_dirty[i] = 0;
            end
            tlb_ptr = 0; frame_ptr = 0; clock_now = 0;
            misses = 0; faults = 0; writebacks = 0; mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_FRAMES:   n_frames = val;
                CFG_TLB:      n_tlb = val[4:0];
                CFG_SHIFT:    shift = val[4:0];
                CFG_PAGE_LRU: page_lru = val[0];
                CFG_TLB_LRU:  tlb_lru = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned oldest_tlb(int unsigned n);
            int unsigned pos;
            pos = 0;
            for (int unsigned i = 1; i < n; i++)
                if (tlb_stamp[i] < tlb_stamp[pos]) pos = i;
            return pos;
        endfunction

        function int unsigned oldest_frame(int unsigned n);
            int unsigned pos;
            pos = 0;
            for (int unsigned i = 1; i < n; i++)
                if (frame_stamp[i] < frame_stamp[pos]) pos = i;
            return pos;
        endfunction

        function void load_tlb(logic [31:0] pg, int unsigned nt);
            int unsigned p;
            if (tlb_lru) begin
                p = oldest_tlb(nt);
                tlb_ptr = p; tlb_page[p] = pg; tlb_stamp[p] = clock_now;
            end else begin
                p = (tlb_ptr < nt) ? tlb_ptr : 0;
                tlb_page[p] = pg;
                tlb_ptr = (p + 1 >= nt) ? 0 : p + 1;
            end
        endfunction

        function void note_request(tlbprt_req_t rq);
            tlbprt_rsp_t r;
            logic [31:0] pg;
            int unsigned nf, nt, v;
            bit found, seen;
            r = '0;
            pg = rq.address >> shift;
            nf = (n_frames == 0) ? 1 : (n_frames > 64 ? 64 : n_frames);
            nt = (n_tlb == 0) ? 1 : (n_tlb > 16 ? 16 : n_tlb);
            if (nt > nf) nt = nf;
            clock_now++;
            found = 0;
            for (int unsigned i = 0; i < nt && !found; i++)
                if (tlb_page[i] == pg) begin
                    found = 1; tlb_stamp[i] = clock_now;
                end
            if (found) begin
                r.tlb_hit = 1; seen = 0;
                for (int unsigned i = 0; i < nf; i++)
                    if (frame_page[i] == pg) begin
                        if (!seen) begin r.frame_slot = 6'(i); seen = 1; end
                        frame_stamp[i] = clock_now;
                        if (rq.action) frame_dirty[i] = 1;
                    end
            end else begin
                misses++;
                for (int unsigned i = 0; i < nf && !found; i++)
                    if (frame_page[i] == pg) begin
                        found = 1; v = i;
                    end
                if (found) begin
                    r.frame_slot = 6'(v);
                    load_tlb(pg, nt);
                    frame_stamp[v] = clock_now;
                    if (rq.action) frame_dirty[v] = 1;
                end else begin
                    r.page_fault = 1; faults++;
                    v = page_lru ? oldest_frame(nf) : (frame_ptr < nf ? frame_ptr : 0);
                    if (frame_dirty[v]) begin
                        r.wrote_back = 1; writebacks++; frame_dirty[v] = 0;
                    end
                    frame_page[v] = pg;
                    if (page_lru) begin
                        frame_ptr = v; frame_stamp[v] = clock_now;
                    end else begin
                        frame_ptr = (v + 1 >= nf) ? 0 : v + 1;
                    end
                    r.frame_slot = 6'(v);
                    load_tlb(pg, nt);
                    if (rq.action)
                        for (int unsigned i = 0; i < nf; i++)
                            if (frame_page[i] == pg) frame_dirty[i] = 1;
                end
            end
            r.tlb_miss_total = misses;
            r.page_fault_total = faults;
            r.disk_write_total = writebacks;
            pending.push_back(r);
        endfunction

        function void check_result(tlbprt_rsp_t got);
            tlbprt_rsp_t exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got.tlb_hit !== exp.tlb_hit || got.page_fault !== exp.page_fault ||
                got.wrote_back !== exp.wrote_back || got.frame_slot !== exp.frame_slot ||
                got.tlb_miss_total !== exp.tlb_miss_total ||
                got.page_fault_total !== exp.page_fault_total ||
                got.disk_write_total !== exp.disk_write_total) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected hit %b fault %b wb %b slot %0d ",
                        exp.tlb_hit, exp.page_fault, exp.wrote_back, exp.frame_slot,
                        "totals %0d %0d %0d, ",
                        exp.tlb_miss_total, exp.page_fault_total, exp.disk_write_total,
                        "got hit %b fault %b wb %b slot %0d ",
                        got.tlb_hit, got.page_fault, got.wrote_back, got.frame_slot,
                        "totals %0d %0d %0d",
                        got.tlb_miss_total, got.page_fault_total, got.disk_write_total);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    tlbprt_req_t           s_data;
    logic                  m_valid;
    logic                  m_ready;
    tlbprt_rsp_t           m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tracker_scoreboard tracker;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  recv_hold;
    logic [31:0] page_pool [8];

    tlb_page_replacement_tracker dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        aclk = 1'b0; #10;
        aclk = 1'b1; #10;
    end

    // result side: random stall, or a long hold when asked
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) tracker.check_result(m_data);
        if (!aresetn || recv_hold) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // valid stays high into the next request unless an idle cycle comes between
    task automatic send_request(input logic act, input logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{action: act, address: addr};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_request(s_data);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        tracker.set_reg(idx, val);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(input int fr, input int tl, input int sh, input bit pl, input bit tlr);
        drain();
        write_reg(CFG_FRAMES, 7'(fr));
        write_reg(CFG_TLB, 7'(tl));
        write_reg(CFG_SHIFT, 7'(sh));
        write_reg(CFG_PAGE_LRU, {6'd0, pl});
        write_reg(CFG_TLB_LRU, {6'd0, tlr});
    endtask

    // mostly reuse a small working set of pages so hits and evictions both occur
    task automatic random_phase(input int count, input int sh);
        logic [31:0] pg, lowbits;
        for (int i = 0; i < 8; i++) page_pool[i] = $urandom_range(20);
        for (int i = 0; i < count; i++) begin
            lowbits = $urandom();
            if ($urandom_range(9) == 0) send_request(1'($urandom_range(1)), $urandom());
            else begin
                pg = page_pool[$urandom_range(7)];
                if ($urandom_range(3) == 0) pg = $urandom_range(40);
                send_request(1'($urandom_range(1)),
                             (pg << sh) | (lowbits & ((32'd1 << sh) - 1)));
            end
        end
    endtask

    initial begin
        #2000000000;
        $display("tlb_page_replacement_tracker test failed");
        $finish;
    end

    initial begin
        tracker = new();
        aresetn = 1'b0; s_valid = 1'b0; s_data = '0; m_ready = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        send_idle_pct = 0; recv_stall_pct = 0; recv_hold = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, stale hits, dirty write-back
        send_request(1'b0, 32'h0000_0000);
        send_request(1'b1, 32'hFFFF_FFFF);
        send_request(1'b1, 32'h0000_1000);
        send_request(1'b0, 32'h0001_0000);
        send_request(1'b1, 32'h0004_0000);
        send_request(1'b0, 32'h0000_0FFF);
        set_all(2, 2, 1, 0, 0);
        send_request(1'b1, 32'd0);
        send_request(1'b1, 32'd2);
        send_request(1'b1, 32'd4);
        send_request(1'b0, 32'd0);
        send_request(1'b0, 32'd6);
        set_all(0, 0, 31, 1, 1);
        send_request(1'b1, 32'h8000_0000);
        send_request(1'b0, 32'h7FFF_FFFF);
        send_request(1'b1, 32'hAAAA_AAAA);
        set_all(3, 31, 1, 1, 1);
        send_request(1'b1, 32'd2);
        send_request(1'b1, 32'd4);
        send_request(1'b1, 32'd6);
        send_request(1'b0, 32'd8);
        send_request(1'b0, 32'd2);
        set_all(127, 4, 1, 0, 1);
        send_request(1'b1, 32'h5555_5555);
        send_request(1'b0, 32'd3);

        set_all(64, 16, 12, 0, 0);
        random_phase(250, 12);
        set_all(8, 4, 3, 1, 1);
        send_idle_pct = 79;
        random_phase(250, 3);
        set_all(5, 5, 1, 0, 1);
        send_idle_pct = 0; recv_stall_pct = 79;
        random_phase(250, 1);
        set_all(16, 8, 6, 1, 0);
        send_idle_pct = 26; recv_stall_pct = 26;
        random_phase(250, 6);

        // long hold on the result side while requests keep coming
        set_all(1, 1, 2, 1, 1);
        send_idle_pct = 0; recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1;
                repeat (300) @(posedge aclk);
                recv_hold = 0;
            end
            random_phase(20, 2);
        join
        drain();
        random_phase(230, 2);
        set_all(64, 16, 31, 1, 0);
        random_phase(250, 31);
        set_all(12, 16, 4, 0, 1);
        send_idle_pct = 79; recv_stall_pct = 79;
        random_phase(250, 4);

        drain();
        repeat (40) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending.size() == 0)
            $display("tlb_page_replacement_tracker test passed");
        else
            $display("tlb_page_replacement_tracker test failed");
        $finish;
    end
endmodule

[tlb_page_replacement_tracker.f]
rtl/core/tlbprt_pkg.sv
rtl/core/tlbprt_cell.sv
rtl/core/tlbprt_chain.sv
rtl/core/tlb_page_replacement_tracker.sv
bench/tlb_page_replacement_tracker_tb.sv
